/* rtl/pssr_pkg.sv */
// Shared types and codes for the scroll and register unit.
// Used by pssr_core and ppu_scroll_address_registers_core; depends on nothing.
package pssr_pkg;

  // Kind of transaction on the input stream.
  typedef enum logic [2:0] {
    ModeRegWrite    = 3'd0,
    ModeRegRead     = 3'd1,
    ModeIncX        = 3'd2,
    ModeIncY        = 3'd3,
    ModeCopyX       = 3'd4,
    ModeCopyY       = 3'd5,
    ModeVblankStart = 3'd6,
    ModeVblankEnd   = 3'd7
  } mode_e;

  // CPU-visible register numbers.
  typedef enum logic [2:0] {
    RegControl = 3'd0,
    RegMask    = 3'd1,
    RegStatus  = 3'd2,
    RegOamAddr = 3'd3,
    RegOamData = 3'd4,
    RegScroll  = 3'd5,
    RegAddress = 3'd6,
    RegData    = 3'd7
  } reg_e;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned InTuserW  = 6;
  localparam int unsigned OutTdataW = 56;
  localparam int unsigned OutTuserW = 3;

  // One input transaction.
  typedef struct packed {
    mode_e      mode;
    reg_e       reg_index;
    logic [7:0] write_data;
    logic [7:0] mem_data;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        mem_write;
    logic        mem_read;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [15:0] current_addr;
    logic [2:0]  fine_scroll_x;
    logic        nmi_pulse;
  } result_t;

endpackage

/* rtl/ppu_scroll_address_registers_core.sv */
// Each input transaction passes through the input register and then the result register; one
// transaction per cycle while the result side is not stalled.
// The input register and the result register each hold one transaction; the input side
// stalls only while both are full and the result transaction is not taken.
// Reset (rst_ni low, asynchronous) clears both valid flags and all scroll state.
// Top level of the scroll and register unit; depends on pssr_pkg and pssr_core.
module ppu_scroll_address_registers_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] write_data, [15:8] mem_data
  input  logic [pssr_pkg::InTdataW-1:0]   s_axis_tdata,
  // [2:0] mode, [5:3] reg_index
  input  logic [pssr_pkg::InTuserW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] read_data, [23:8] mem_addr, [31:24] mem_wdata, [47:32] current_addr,
  // [50:48] fine_scroll_x, [55:51] zero
  output logic [pssr_pkg::OutTdataW-1:0]  m_axis_tdata,
  // [0] mem_write, [1] mem_read, [2] nmi_pulse
  output logic [pssr_pkg::OutTuserW-1:0]  m_axis_tuser
);

  logic              in_valid_q;
  pssr_pkg::item_t   in_item_q;
  logic              out_valid_q;
  pssr_pkg::result_t out_q;
  pssr_pkg::result_t result;
  logic              step;

  // The held transaction moves on when the result register is free or draining.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.mode       <= pssr_pkg::mode_e'(s_axis_tuser[2:0]);
      in_item_q.reg_index  <= pssr_pkg::reg_e'(s_axis_tuser[5:3]);
      in_item_q.write_data <= s_axis_tdata[7:0];
      in_item_q.mem_data   <= s_axis_tdata[15:8];
    end
  end

  pssr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.fine_scroll_x, out_q.current_addr, out_q.mem_wdata,
                          out_q.mem_addr, out_q.read_data};
  assign m_axis_tuser  = {out_q.nmi_pulse, out_q.mem_read, out_q.mem_write};

  // The input side only stalls behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without back pressure");

  // A result never reports a memory write and a memory read together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("memory write and read in one result");

  // Without a memory access the reported access address is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tdata[23:8] == 16'd0)
    else $error("access address set without a memory access");

endmodule

/* rtl/pssr_core.sv */
// Scroll and register state with its update logic for one transaction.
// Depends on pssr_pkg; instantiated by ppu_scroll_address_registers_core.
module pssr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pssr_pkg::item_t  item_i,
  output pssr_pkg::result_t result_o
);

  localparam logic [15:0] MaskCopyX = 16'h041f;
  localparam logic [15:0] MaskCopyY = 16'h7be0;
  localparam logic [15:0] PaletteBase = 16'h3f00;

  logic [7:0]  control_q, control_d;
  logic [7:0]  mask_q, mask_d;
  logic        vblank_q, vblank_d;
  logic        toggle_q, toggle_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic [15:0] taddr_q, taddr_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic        render_on;
  logic [15:0] addr_step;

  // Coarse X step with horizontal nametable flip on wrap.
  function automatic logic [15:0] inc_x(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~v[10];
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

  // Fine Y step, carrying into coarse Y with the row-29 wrap.
  function automatic logic [15:0] inc_y(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (v[9:5] == 5'd29) begin
        r[9:5] = 5'd0;
        r[11]  = ~v[11];
      end else if (v[9:5] == 5'd31) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = v[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

  assign render_on = mask_q[3] | mask_q[4];
  assign addr_step = control_q[2] ? 16'd32 : 16'd1;

  // Next state and result for the transaction in the input register.
  always_comb begin
    control_d = control_q;
    mask_d    = mask_q;
    vblank_d  = vblank_q;
    toggle_d  = toggle_q;
    fine_x_d  = fine_x_q;
    taddr_d   = taddr_q;
    vaddr_d   = vaddr_q;
    rbuf_d    = rbuf_q;
    result_o  = '0;
    result_o.read_data = 8'hff;

    unique case (item_i.mode)
      pssr_pkg::ModeRegWrite: begin
        unique case (item_i.reg_index)
          pssr_pkg::RegControl: begin
            control_d      = item_i.write_data;
            taddr_d[11:10] = item_i.write_data[1:0];
          end
          pssr_pkg::RegMask: begin
            mask_d = item_i.write_data;
          end
          pssr_pkg::RegScroll: begin
            if (!toggle_q) begin
              fine_x_d     = item_i.write_data[2:0];
              taddr_d[4:0] = item_i.write_data[7:3];
            end else begin
              taddr_d[14:12] = item_i.write_data[2:0];
              taddr_d[9:5]   = item_i.write_data[7:3];
            end
            toggle_d = ~toggle_q;
          end
          pssr_pkg::RegAddress: begin
            if (!toggle_q) begin
              taddr_d[15:8] = {2'b00, item_i.write_data[5:0]};
            end else begin
              taddr_d[7:0] = item_i.write_data;
              vaddr_d      = {taddr_q[15:8], item_i.write_data};
            end
            toggle_d = ~toggle_q;
          end
          pssr_pkg::RegData: begin
            result_o.mem_write = 1'b1;
            result_o.mem_addr  = vaddr_q;
            result_o.mem_wdata = item_i.write_data;
            vaddr_d            = vaddr_q + addr_step;
          end
          default: begin
          end
        endcase
      end
      pssr_pkg::ModeRegRead: begin
        unique case (item_i.reg_index)
          pssr_pkg::RegControl: result_o.read_data = control_q;
          pssr_pkg::RegMask:    result_o.read_data = mask_q;
          pssr_pkg::RegStatus: begin
            result_o.read_data = {vblank_q, 2'b00, rbuf_q[4:0]};
            vblank_d = 1'b0;
            toggle_d = 1'b0;
          end
          pssr_pkg::RegData: begin
            // Palette space returns the fresh byte, the rest the old buffer.
            result_o.mem_read  = 1'b1;
            result_o.mem_addr  = vaddr_q;
            result_o.read_data = (vaddr_q >= PaletteBase) ? item_i.mem_data : rbuf_q;
            rbuf_d             = item_i.mem_data;
            vaddr_d            = vaddr_q + addr_step;
          end
          default: begin
          end
        endcase
      end
      pssr_pkg::ModeIncX: begin
        if (render_on) vaddr_d = inc_x(vaddr_q);
      end
      pssr_pkg::ModeIncY: begin
        if (render_on) vaddr_d = inc_y(vaddr_q);
      end
      pssr_pkg::ModeCopyX: begin
        if (render_on) vaddr_d = (vaddr_q & ~MaskCopyX) | (taddr_q & MaskCopyX);
      end
      pssr_pkg::ModeCopyY: begin
        if (render_on) vaddr_d = (vaddr_q & ~MaskCopyY) | (taddr_q & MaskCopyY);
      end
      pssr_pkg::ModeVblankStart: begin
        vblank_d           = 1'b1;
        result_o.nmi_pulse = control_q[7];
      end
      pssr_pkg::ModeVblankEnd: begin
        vblank_d = 1'b0;
      end
      default: begin
      end
    endcase

    result_o.current_addr  = vaddr_d;
    result_o.fine_scroll_x = fine_x_d;
  end

  // State registers advance once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0;
      mask_q    <= '0;
      vblank_q  <= 1'b0;
      toggle_q  <= 1'b0;
      fine_x_q  <= '0;
      taddr_q   <= '0;
      vaddr_q   <= '0;
      rbuf_q    <= '0;
    end else if (step_i) begin
      control_q <= control_d;
      mask_q    <= mask_d;
      vblank_q  <= vblank_d;
      toggle_q  <= toggle_d;
      fine_x_q  <= fine_x_d;
      taddr_q   <= taddr_d;
      vaddr_q   <= vaddr_d;
      rbuf_q    <= rbuf_d;
    end
  end

  // The second address write loads the current address from the temporary one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == pssr_pkg::ModeRegWrite &&
    item_i.reg_index == pssr_pkg::RegAddress && toggle_q |=> vaddr_q == taddr_q)
    else $error("address load did not copy temporary address");

  // Vblank end always leaves the flag clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == pssr_pkg::ModeVblankEnd |=> !vblank_q)
    else $error("vblank flag survived vblank end");

  // Temporary address bit 15 can never be set by any write.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !taddr_q[15])
    else $error("temporary address bit 15 set");

endmodule

/* dv/ppu_scroll_address_registers_core_test.sv */
// Self-checking testbench for the scroll and register unit (ppu_scroll_address_registers_core).
// Depends on pssr_pkg for the transaction types and the mode and register codes.
module ppu_scroll_address_registers_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pssr_pkg::*;

  localparam int unsigned RandomItems = 1650;
  localparam int unsigned QuietItems  = 200;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [15:0] PaletteBase = 16'h3f00;

  // Tracks the unit's scroll state and checks every result transaction in order.
  class scroll_scoreboard;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic        vblank_q;
    logic        toggle_q;
    logic [2:0]  fine_x_q;
    logic [15:0] temp_addr_q;
    logic [15:0] vram_addr_q;
    logic [7:0]  read_buf_q;
    result_t     due_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned data_accesses;
    int unsigned nmi_count;

    function new();
      ctrl_q        = '0;
      mask_q        = '0;
      vblank_q      = 1'b0;
      toggle_q      = 1'b0;
      fine_x_q      = '0;
      temp_addr_q   = '0;
      vram_addr_q   = '0;
      read_buf_q    = '0;
      errors        = 0;
      checked       = 0;
      data_accesses = 0;
      nmi_count     = 0;
    endfunction

    // Applies one accepted transaction to the state and queues the result it causes.
    function void note_item(item_t it);
      result_t     r;
      logic [15:0] addr_step;
      logic        rendering;
      r           = '0;
      r.read_data = 8'hff;
      addr_step   = ctrl_q[2] ? 16'd32 : 16'd1;
      rendering   = mask_q[3] | mask_q[4];
      case (it.mode)
        ModeRegWrite: begin
          case (it.reg_index)
            RegControl: begin
              ctrl_q = it.write_data;
              temp_addr_q[11:10] = it.write_data[1:0];
            end
            RegMask: mask_q = it.write_data;
            RegScroll: begin
              if (!toggle_q) begin
                fine_x_q = it.write_data[2:0];
                temp_addr_q[4:0] = it.write_data[7:3];
              end else begin
                temp_addr_q[14:12] = it.write_data[2:0];
                temp_addr_q[9:5] = it.write_data[7:3];
              end
              toggle_q = ~toggle_q;
            end
            RegAddress: begin
              // The high byte keeps six bits only.
              if (!toggle_q) begin
                temp_addr_q[15:8] = {2'b00, it.write_data[5:0]};
              end else begin
                temp_addr_q[7:0] = it.write_data;
                vram_addr_q = temp_addr_q;
              end
              toggle_q = ~toggle_q;
            end
            RegData: begin
              r.mem_write = 1'b1;
              r.mem_addr  = vram_addr_q;
              r.mem_wdata = it.write_data;
              vram_addr_q = vram_addr_q + addr_step;
              data_accesses++;
            end
            default: ;
          endcase
        end
        ModeRegRead: begin
          case (it.reg_index)
            RegControl: r.read_data = ctrl_q;
            RegMask:    r.read_data = mask_q;
            RegStatus: begin
              r.read_data = {vblank_q, 2'b00, read_buf_q[4:0]};
              vblank_q = 1'b0;
              toggle_q = 1'b0;
            end
            RegData: begin
              // Palette reads bypass the buffer delay.
              r.mem_read  = 1'b1;
              r.mem_addr  = vram_addr_q;
              r.read_data = (vram_addr_q >= PaletteBase) ? it.mem_data : read_buf_q;
              read_buf_q  = it.mem_data;
              vram_addr_q = vram_addr_q + addr_step;
              data_accesses++;
            end
            default: ;
          endcase
        end
        ModeIncX: begin
          if (rendering) begin
            if (vram_addr_q[4:0] == 5'd31) begin
              vram_addr_q[4:0] = 5'd0;
              vram_addr_q[10] = ~vram_addr_q[10];
            end else begin
              vram_addr_q[4:0] = vram_addr_q[4:0] + 5'd1;
            end
          end
        end
        ModeIncY: begin
          if (rendering) begin
            if (vram_addr_q[14:12] != 3'd7) begin
              vram_addr_q[14:12] = vram_addr_q[14:12] + 3'd1;
            end else begin
              vram_addr_q[14:12] = 3'd0;
              // Row 29 is the last visible row; row 31 wraps to 0 without a flip.
              if (vram_addr_q[9:5] == 5'd29) begin
                vram_addr_q[9:5] = 5'd0;
                vram_addr_q[11] = ~vram_addr_q[11];
              end else begin
                vram_addr_q[9:5] = vram_addr_q[9:5] + 5'd1;
              end
            end
          end
        end
        ModeCopyX: begin
          if (rendering) begin
            vram_addr_q[4:0] = temp_addr_q[4:0];
            vram_addr_q[10] = temp_addr_q[10];
          end
        end
        ModeCopyY: begin
          if (rendering) begin
            vram_addr_q[9:5] = temp_addr_q[9:5];
            vram_addr_q[11] = temp_addr_q[11];
            vram_addr_q[14:12] = temp_addr_q[14:12];
          end
        end
        ModeVblankStart: begin
          vblank_q = 1'b1;
          r.nmi_pulse = ctrl_q[7];
          if (ctrl_q[7]) nmi_count++;
        end
        default: vblank_q = 1'b0;
      endcase
      r.current_addr  = vram_addr_q;
      r.fine_scroll_x = fine_x_q;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compares one result transaction with the oldest queued result.
    function void check_result(result_t got, logic [4:0] pad);
      result_t exp_r;
      if (due_results.size() == 0) begin
        $error("result transaction arrived with none outstanding");
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      checked++;
      compare_field("read_data", exp_r.read_data, got.read_data);
      compare_field("mem_write", exp_r.mem_write, got.mem_write);
      compare_field("mem_read", exp_r.mem_read, got.mem_read);
      compare_field("mem_addr", exp_r.mem_addr, got.mem_addr);
      compare_field("mem_wdata", exp_r.mem_wdata, got.mem_wdata);
      compare_field("current_addr", exp_r.current_addr, got.current_addr);
      compare_field("fine_scroll_x", exp_r.fine_scroll_x, got.fine_scroll_x);
      compare_field("nmi_pulse", exp_r.nmi_pulse, got.nmi_pulse);
      compare_field("tdata padding", '0, pad);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [InTuserW-1:0]  s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;

  scroll_scoreboard sb;
  int unsigned      items_sent;
  bit               quiet;

  ppu_scroll_address_registers_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Result monitor: every result transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_data     = m_axis_tdata[7:0];
      got.mem_addr      = m_axis_tdata[23:8];
      got.mem_wdata     = m_axis_tdata[31:24];
      got.current_addr  = m_axis_tdata[47:32];
      got.fine_scroll_x = m_axis_tdata[50:48];
      got.mem_write     = m_axis_tuser[0];
      got.mem_read      = m_axis_tuser[1];
      got.nmi_pulse     = m_axis_tuser[2];
      sb.check_result(got, m_axis_tdata[55:51]);
    end
  end

  // Result-side back-pressure in random bursts; none in the quiet tail.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
  end

  // Run limit.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("ppu_scroll_address_registers_core regression: fail");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic item_t mk(mode_e m, reg_e r, logic [7:0] wd, logic [7:0] md);
    item_t it;
    it.mode       = m;
    it.reg_index  = r;
    it.write_data = wd;
    it.mem_data   = md;
    return it;
  endfunction

  // Renderer event with random contents in the fields it ignores.
  function automatic item_t render_item(mode_e m);
    return mk(m, reg_e'($urandom_range(0, 7)), rnd8(), rnd8());
  endfunction

  // Mask byte with rendering enabled most of the time.
  function automatic logic [7:0] mask_byte();
    logic [7:0] v;
    v = rnd8();
    if ($urandom_range(0, 3) != 0 && v[4:3] == 2'b00) v[3 + $urandom_range(0, 1)] = 1'b1;
    return v;
  endfunction

  // Drives one input transaction, with an occasional gap before it, and waits for acceptance.
  // Called and returns at a falling edge.
  task automatic send(item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.mem_data, it.write_data};
    s_axis_tuser  <= {it.reg_index, it.mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic data_accesses(int unsigned n);
    repeat (n) begin
      send(mk(($urandom_range(0, 1) != 0) ? ModeRegRead : ModeRegWrite, RegData, rnd8(),
              rnd8()));
    end
  endtask

  // CPU setup sequence: status read, optional control and mask, scroll and address pairs, then data accesses.
  task automatic cpu_setup_sequence();
    logic [7:0] hi;
    hi = rnd8();
    if ($urandom_range(0, 3) == 0) hi[5:0] = 6'h3f;
    send(mk(ModeRegRead, RegStatus, rnd8(), rnd8()));
    if ($urandom_range(0, 1) != 0) send(mk(ModeRegWrite, RegControl, rnd8(), rnd8()));
    if ($urandom_range(0, 1) != 0) send(mk(ModeRegWrite, RegMask, mask_byte(), rnd8()));
    send(mk(ModeRegWrite, RegScroll, rnd8(), rnd8()));
    send(mk(ModeRegWrite, RegScroll, rnd8(), rnd8()));
    send(mk(ModeRegWrite, RegAddress, hi, rnd8()));
    send(mk(ModeRegWrite, RegAddress, rnd8(), rnd8()));
    data_accesses($urandom_range(1, 8));
  endtask

  // A stretch of renderer events, half of them horizontal increments.
  task automatic render_run();
    int unsigned k;
    repeat ($urandom_range(8, 40)) begin
      k = $urandom_range(0, 9);
      if (k < 5)       send(render_item(ModeIncX));
      else if (k < 7)  send(render_item(ModeIncY));
      else if (k == 7) send(render_item(ModeCopyX));
      else             send(render_item(ModeCopyY));
    end
  endtask

  task automatic vblank_sequence();
    send(render_item(ModeVblankStart));
    repeat ($urandom_range(0, 3)) send(mk(ModeRegRead, RegStatus, rnd8(), rnd8()));
    data_accesses($urandom_range(0, 4));
    send(render_item(ModeVblankEnd));
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 10)) begin
      send(mk(mode_e'($urandom_range(0, 7)), reg_e'($urandom_range(0, 7)), rnd8(), rnd8()));
    end
  endtask

  // Directed opening: each operation, the register corner cases and the scroll wraps.
  task automatic directed_items();
    send(mk(ModeVblankStart, RegControl, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegStatus, 8'h00, 8'h00));
    send(mk(ModeRegWrite, RegControl, 8'hff, 8'h00));
    send(mk(ModeVblankStart, RegControl, 8'h00, 8'hff));
    send(mk(ModeRegRead, RegControl, 8'h00, 8'h00));
    send(mk(ModeRegWrite, RegMask, 8'h18, 8'h00));
    send(mk(ModeRegRead, RegMask, 8'h00, 8'h00));
    send(mk(ModeRegWrite, RegStatus, 8'hff, 8'hff));
    send(mk(ModeRegWrite, RegOamAddr, 8'hff, 8'hff));
    send(mk(ModeRegWrite, RegOamData, 8'hff, 8'hff));
    send(mk(ModeRegRead, RegOamAddr, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegOamData, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegScroll, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegAddress, 8'h00, 8'h00));
    // High address byte of all ones: the top two bits must be dropped.
    send(mk(ModeRegWrite, RegAddress, 8'hff, 8'h00));
    send(mk(ModeRegWrite, RegAddress, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegData, 8'h00, 8'ha5));
    send(mk(ModeRegWrite, RegData, 8'hff, 8'h00));
    // Coarse X of 31 and coarse Y of 31 with fine Y of 7.
    send(mk(ModeRegWrite, RegScroll, 8'hff, 8'h00));
    send(mk(ModeRegWrite, RegScroll, 8'hff, 8'h00));
    send(mk(ModeCopyX, RegControl, 8'h00, 8'h00));
    send(mk(ModeIncX, RegControl, 8'h00, 8'h00));
    send(mk(ModeCopyY, RegControl, 8'h00, 8'h00));
    send(mk(ModeIncY, RegControl, 8'h00, 8'h00));
    // Coarse Y of 29 with fine Y of 7 flips the vertical nametable.
    send(mk(ModeRegWrite, RegScroll, 8'h00, 8'h00));
    send(mk(ModeRegWrite, RegScroll, 8'hef, 8'h00));
    send(mk(ModeCopyY, RegControl, 8'h00, 8'h00));
    send(mk(ModeIncY, RegControl, 8'h00, 8'h00));
    send(mk(ModeVblankEnd, RegControl, 8'h00, 8'h00));
    // Rendering off: the increment must leave the address alone.
    send(mk(ModeRegWrite, RegMask, 8'h00, 8'h00));
    send(mk(ModeIncY, RegControl, 8'h00, 8'h00));
    send(mk(ModeRegRead, RegData, 8'h00, 8'h5a));
    send(mk(ModeRegRead, RegStatus, 8'h00, 8'h00));
  endtask

  // Main sequence.
  initial begin
    int unsigned kind;
    int unsigned total;
    sb            = new();
    items_sent    = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_items();
    total = items_sent + RandomItems;
    while (items_sent < total) begin
      if (items_sent + QuietItems >= total) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 3)       cpu_setup_sequence();
      else if (kind < 7)  render_run();
      else if (kind == 7) vblank_sequence();
      else                noise();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d transactions (directed corner cases, then CPU setup, render and vblank",
             items_sent);
    $display("sequences with noise); checked %0d results, %0d data-port accesses, %0d NMIs.",
             sb.checked, sb.data_accesses, sb.nmi_count);
    if (sb.errors == 0) begin
      $display("ppu_scroll_address_registers_core regression: pass");
    end else begin
      $display("ppu_scroll_address_registers_core regression: fail");
    end
    $finish;
  end

endmodule

/* ppu_scroll_address_registers_core.f */
rtl/pssr_pkg.sv
rtl/pssr_core.sv
rtl/ppu_scroll_address_registers_core.sv
dv/ppu_scroll_address_registers_core_test.sv
